// ===== src/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types and constants of the tilt complementary filter: CORDIC angle
// table, fixed-point formats, blend constants and register map.
// ----------------------------------------------------------------------------
package tcf_pkg;

  // CORDIC vector and angle accumulator widths
  localparam int unsigned VEC_W      = 32;  // raw operand * 4096 plus CORDIC gain
  localparam int unsigned ANG_W      = 30;  // angle in 2^-20 degree
  localparam int unsigned ATAN_LEN   = 24;  // entries in the arctangent table
  localparam int unsigned PRE_SHIFT  = 12;  // operands scaled by 4096
  localparam int unsigned OUT_SHIFT  = 13;  // 2^-20 deg -> 1/128 deg
  localparam logic signed [ANG_W-1:0] ANGLE_90   = 30'sd94371840;
  localparam logic signed [ANG_W-1:0] ROUND_BIAS = 30'sd4096;

  // Blend: result = round(N / 65536000) = floor(floor((|N| + 32768000) / 2^19) / 125)
  localparam int unsigned         DEN_SHIFT   = 19;
  localparam logic [50:0]         HALF_DEN    = 51'd32768000;
  localparam logic [22:0]         RECIP_125   = 23'd4294967;  // floor(2^29 / 125)
  localparam int unsigned         RECIP_SHIFT = 29;
  localparam logic [31:0]         SAT_LIMIT   = 32'd4096000;  // 125 * 32768
  localparam logic [22:0]         DIVISOR     = 23'd125;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_PITCH_OFFSET = 2'd0,
    REG_ROLL_OFFSET  = 2'd1,
    REG_STEP_TIME    = 2'd2,
    REG_GYRO_WEIGHT  = 2'd3
  } reg_idx_e;

  localparam logic [15:0] GYRO_WEIGHT_RST = 16'd655;

  // Request to the CORDIC unit: atan2(num, den)
  typedef struct packed {
    logic signed [16:0] num;
    logic signed [15:0] den;
  } cordic_req_t;

  // Request to the blend unit
  typedef struct packed {
    logic signed [15:0] prev;
    logic signed [15:0] gyro;
    logic signed [15:0] angle;
  } blend_req_t;

  // atan(2^-i) in 2^-20 degree, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 30'sd47185920;
      5'd1:  v = 30'sd27855475;
      5'd2:  v = 30'sd14718068;
      5'd3:  v = 30'sd7471121;
      5'd4:  v = 30'sd3750058;
      5'd5:  v = 30'sd1876857;
      5'd6:  v = 30'sd938658;
      5'd7:  v = 30'sd469357;
      5'd8:  v = 30'sd234682;
      5'd9:  v = 30'sd117342;
      5'd10: v = 30'sd58671;
      5'd11: v = 30'sd29335;
      5'd12: v = 30'sd14668;
      5'd13: v = 30'sd7334;
      5'd14: v = 30'sd3667;
      5'd15: v = 30'sd1833;
      5'd16: v = 30'sd917;
      5'd17: v = 30'sd458;
      5'd18: v = 30'sd229;
      5'd19: v = 30'sd115;
      5'd20: v = 30'sd57;
      5'd21: v = 30'sd29;
      5'd22: v = 30'sd14;
      5'd23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/tcf_cordic.sv =====
// ----------------------------------------------------------------------------
// tcf_cordic
// Iterative vectoring CORDIC: atan2(num, den) in 1/128 degree. One shared
// shift/add-subtract datapath, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tcf_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tcf_pkg::cordic_req_t req_i,
  output logic                busy_o,
  output logic signed [15:0]  angle_o
);
  import tcf_pkg::*;

  localparam int unsigned NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int unsigned CNT_W  = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

  logic                    busy_q, busy_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [VEC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  logic                    zero_q, zero_d;

  logic signed [VEC_W-1:0] xs, ys, dx, dy;
  logic signed [ANG_W-1:0] at, z_rnd;

  // scaled operands
  assign xs = VEC_W'(req_i.den) <<< PRE_SHIFT;
  assign ys = VEC_W'(req_i.num) <<< PRE_SHIFT;

  // shared shifter and table lookup
  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = atan_lut(5'(cnt_q));

  // load / micro-rotation
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      zero_d = (req_i.num == '0) && (req_i.den == '0);
      if (xs < 0) begin
        // quadrant fold by +-90 degrees
        if (ys >= 0) begin
          x_d = ys;
          y_d = -xs;
          z_d = ANGLE_90;
        end else begin
          x_d = -ys;
          y_d = xs;
          z_d = -ANGLE_90;
        end
      end else begin
        x_d = xs;
        y_d = ys;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end
      if (cnt_q == CNT_W'(NSTEPS - 1)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  // round half up to 1/128 degree; zero vector gives zero
  assign z_rnd   = z_q + ROUND_BIAS;
  assign angle_o = zero_q ? '0 : z_rnd[OUT_SHIFT+15:OUT_SHIFT];
  assign busy_o  = busy_q;

endmodule

// ===== src/tcf_blend.sv =====
// ----------------------------------------------------------------------------
// tcf_blend
// Complementary blend of one angle: weighted gyro path plus accelerometer
// angle, rounded division by 65536000 and 16-bit saturation. One shared
// multiplier, stepped by a one-hot phase sequencer.
// ----------------------------------------------------------------------------
module tcf_blend (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tcf_pkg::blend_req_t req_i,
  input  logic [15:0]         weight_i,
  input  logic [9:0]          step_ms_i,
  output logic                busy_o,
  output logic signed [15:0]  result_o
);
  import tcf_pkg::*;

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001,
    PH_GMUL = 9'b000000010,  // gyro * dt
    PH_SUM  = 9'b000000100,  // gyro*dt*128 + prev*1000
    PH_WMUL = 9'b000001000,  // * w
    PH_CMUL = 9'b000010000,  // angle*1000 * (65536 - w)
    PH_ADD  = 9'b000100000,  // N
    PH_MAG  = 9'b001000000,  // (|N| + half) >> 19
    PH_RMUL = 9'b010000000,  // * reciprocal of 125
    PH_FIN  = 9'b100000000   // correct, saturate, sign
  } phase_e;

  function automatic logic signed [25:0] times_1000(input logic signed [15:0] v);
    logic signed [25:0] e;
    e = 26'(v);
    return (e <<< 10) - (e <<< 4) - (e <<< 3);
  endfunction

  phase_e             ph_q, ph_d;
  logic signed [15:0] gyro_q;
  logic signed [25:0] prev1k_q, ang1k_q;
  logic signed [57:0] prod_q;
  logic signed [33:0] s1_q;
  logic signed [49:0] m1_q;
  logic signed [50:0] n_q;
  logic               neg_q;
  logic [31:0]        mag_q;
  logic signed [15:0] res_q;

  logic signed [33:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [57:0] prod;
  logic [16:0]        wcomp;
  logic signed [25:0] p26;
  logic [50:0]        absn, biased;
  logic [15:0]        q0, qc;
  logic [22:0]        q0x125, rem;
  logic [16:0]        qmag, qneg;
  logic               sat;
  logic signed [15:0] fin;

  assign wcomp = 17'h10000 - {1'b0, weight_i};

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ph_q)
      PH_GMUL: begin
        mul_a = 34'(gyro_q);
        mul_b = {14'b0, step_ms_i};
      end
      PH_WMUL: begin
        mul_a = s1_q;
        mul_b = {8'b0, weight_i};
      end
      PH_CMUL: begin
        mul_a = 34'(ang1k_q);
        mul_b = {7'b0, wcomp};
      end
      PH_RMUL: begin
        mul_a = {12'b0, mag_q[21:0]};
        mul_b = {1'b0, RECIP_125};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // intermediate terms
  assign p26    = $signed(prod_q[25:0]);
  assign absn   = n_q[50] ? 51'(-n_q) : 51'(n_q);
  assign biased = absn + HALF_DEN;

  // quotient correction and saturation
  assign q0     = prod_q[RECIP_SHIFT+15:RECIP_SHIFT];
  assign q0x125 = (23'(q0) << 7) - (23'(q0) << 1) - 23'(q0);
  assign rem    = {1'b0, mag_q[21:0]} - q0x125;
  assign qc     = q0 + 16'(rem >= DIVISOR);
  assign sat    = mag_q >= SAT_LIMIT;
  assign qmag   = sat ? 17'h08000 : {1'b0, qc};
  assign qneg   = 17'd0 - qmag;
  always_comb begin
    if (neg_q) begin
      fin = $signed(qneg[15:0]);
    end else if (qmag > 17'h07FFF) begin
      fin = 16'sh7FFF;
    end else begin
      fin = $signed(qmag[15:0]);
    end
  end

  // phase sequencer
  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      PH_IDLE: if (start_i) ph_d = PH_GMUL;
      PH_GMUL: ph_d = PH_SUM;
      PH_SUM:  ph_d = PH_WMUL;
      PH_WMUL: ph_d = PH_CMUL;
      PH_CMUL: ph_d = PH_ADD;
      PH_ADD:  ph_d = PH_MAG;
      PH_MAG:  ph_d = PH_RMUL;
      PH_RMUL: ph_d = PH_FIN;
      PH_FIN:  ph_d = PH_IDLE;
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDLE && start_i) begin
      gyro_q   <= req_i.gyro;
      prev1k_q <= times_1000(req_i.prev);
      ang1k_q  <= times_1000(req_i.angle);
    end
    if (ph_q == PH_GMUL || ph_q == PH_WMUL || ph_q == PH_CMUL || ph_q == PH_RMUL) begin
      prod_q <= prod;
    end
    if (ph_q == PH_SUM) begin
      s1_q <= (34'(p26) <<< 7) + 34'(prev1k_q);
    end
    if (ph_q == PH_CMUL) begin
      m1_q <= $signed(prod_q[49:0]);
    end
    if (ph_q == PH_ADD) begin
      n_q <= 51'(m1_q) + 51'($signed(prod_q[41:0]));
    end
    if (ph_q == PH_MAG) begin
      neg_q <= n_q[50];
      mag_q <= biased[DEN_SHIFT+31:DEN_SHIFT];
    end
    if (ph_q == PH_FIN) begin
      res_q <= fin;
    end
  end

  assign busy_o   = (ph_q != PH_IDLE);
  assign result_o = res_q;

endmodule

// ===== src/tilt_complementary_filter.sv =====
// An accepted sample goes through the pitch CORDIC, the roll CORDIC with the pitch blend
// alongside, the roll blend and the output register. The single CORDIC unit does pitch
//   then roll, one micro-rotation per cycle; the blend unit steps through 8 phases.
// The pitch blend overlaps the roll CORDIC; s_axis_tready is high only when idle.
// Reset (async, active low): estimates cleared, offsets and step time zero, weight 655.
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Accelerometer/gyro complementary filter producing pitch and roll in 1/128
// degree. Sequencer, APB register file and stream ports.
// ----------------------------------------------------------------------------
module tilt_complementary_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pitch_angle, roll_angle
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PITCH = 5'b00010,
    S_ROLL  = 5'b00100,
    S_BLEND = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic signed [15:0] pitch_off_q, roll_off_q;
  logic [9:0]         step_ms_q;
  logic [15:0]        weight_q;
  logic signed [15:0] pitch_est_q, pitch_est_d, roll_est_q, roll_est_d;
  logic               m_valid_q, m_valid_d;
  logic [31:0]        m_data_q;
  logic signed [15:0] ay_q, az_q, gx_q, gy_q;

  logic               accept, cfg_wr, out_load;
  logic signed [15:0] in_ax, in_az;
  logic               cord_start, cord_busy, blend_start, blend_busy;
  cordic_req_t        cord_req;
  blend_req_t         blend_req;
  logic signed [15:0] cord_angle, blend_res;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_off_q <= '0;
      roll_off_q  <= '0;
      step_ms_q   <= '0;
      weight_q    <= GYRO_WEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PITCH_OFFSET: pitch_off_q <= $signed(pwdata[15:0]);
        REG_ROLL_OFFSET:  roll_off_q  <= $signed(pwdata[15:0]);
        REG_STEP_TIME:    step_ms_q   <= pwdata[9:0];
        REG_GYRO_WEIGHT:  weight_q    <= pwdata[15:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PITCH_OFFSET: prdata = {16'b0, pitch_off_q};
      REG_ROLL_OFFSET:  prdata = {16'b0, roll_off_q};
      REG_STEP_TIME:    prdata = {22'b0, step_ms_q};
      REG_GYRO_WEIGHT:  prdata = {16'b0, weight_q};
      default:          prdata = '0;
    endcase
  end

  // input request
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_ax         = $signed(s_axis_tdata[15:0]);
  assign in_az         = $signed(s_axis_tdata[47:32]);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ay_q <= $signed(s_axis_tdata[31:16]);
      az_q <= in_az;
      gx_q <= $signed(s_axis_tdata[63:48]);
      gy_q <= $signed(s_axis_tdata[79:64]);
    end
  end

  // CORDIC operands: pitch straight from the bus, roll from the captured sample
  always_comb begin
    if (state_q == S_IDLE) begin
      cord_req.num = 17'(in_ax) - 17'(pitch_off_q);
      cord_req.den = in_az;
    end else begin
      cord_req.num = 17'(ay_q) - 17'(roll_off_q);
      cord_req.den = az_q;
    end
  end

  // blend operands
  always_comb begin
    blend_req.angle = cord_angle;
    if (state_q == S_PITCH) begin
      blend_req.prev = pitch_est_q;
      blend_req.gyro = gx_q;
    end else begin
      blend_req.prev = roll_est_q;
      blend_req.gyro = gy_q;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cord_start  = 1'b0;
    blend_start = 1'b0;
    pitch_est_d = pitch_est_q;
    roll_est_d  = roll_est_q;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cord_start = 1'b1;
          state_d    = S_PITCH;
        end
      end
      S_PITCH: begin
        if (!cord_busy) begin
          blend_start = 1'b1;
          cord_start  = 1'b1;
          state_d     = S_ROLL;
        end
      end
      S_ROLL: begin
        if (!cord_busy && !blend_busy) begin
          pitch_est_d = blend_res;
          blend_start = 1'b1;
          state_d     = S_BLEND;
        end
      end
      S_BLEND: begin
        if (!blend_busy) begin
          roll_est_d = blend_res;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_valid_d = out_load | (m_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pitch_est_q <= '0;
      roll_est_q  <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pitch_est_q <= pitch_est_d;
      roll_est_q  <= roll_est_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {roll_est_q, pitch_est_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  tcf_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .req_i   (cord_req),
    .busy_o  (cord_busy),
    .angle_o (cord_angle)
  );

  tcf_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (blend_start),
    .req_i     (blend_req),
    .weight_i  (weight_q),
    .step_ms_i (step_ms_q),
    .busy_o    (blend_busy),
    .result_o  (blend_res)
  );

endmodule
